### hdl/prtd_pkg.sv
package prtd_pkg;

  // fixed widths of the beat fields
  localparam int FIELD_W = 16;
  localparam int COUNT_W = 7;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_TEST,
    ST_PRIME,
    ST_NEXT,
    ST_FINAL
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;        // take a request beat
    logic start_div;   // divisor = 2, start a division
    logic next_div;    // divisor + 1, start a division
    logic div_step;    // one restoring division step
    logic take_prime;  // candidate is prime, push through pending slot
    logic set_trunc;   // latch truncation flag for the final beat
    logic cand_inc;    // advance to the next candidate
    logic emit_final;  // load the final beat into the output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic cand_lt2;
    logic cand_gt_high;
    logic cand_eq_high;
    logic half_lt2;
    logic div_done;
    logic rem_zero;
    logic next_div_over;
    logic pend_valid;
    logic at_limit;
    logic out_free;
  } sts_t;

endpackage

### hdl/prtd_ctrl.sv
module prtd_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  prtd_pkg::sts_t sts,
  output prtd_pkg::cmd_t cmd
);

  prtd_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= prtd_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      prtd_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = prtd_pkg::ST_CHECK;
      end
      prtd_pkg::ST_CHECK: begin
        if (sts.cand_gt_high) state_nxt = prtd_pkg::ST_FINAL;
        else if (sts.cand_lt2) state_nxt = prtd_pkg::ST_NEXT;
        else if (sts.half_lt2) state_nxt = prtd_pkg::ST_PRIME;
        else state_nxt = prtd_pkg::ST_DIV;
      end
      prtd_pkg::ST_DIV: begin
        if (sts.div_done) state_nxt = prtd_pkg::ST_TEST;
      end
      prtd_pkg::ST_TEST: begin
        if (sts.rem_zero) state_nxt = prtd_pkg::ST_NEXT;
        else if (sts.next_div_over) state_nxt = prtd_pkg::ST_PRIME;
        else state_nxt = prtd_pkg::ST_DIV;
      end
      prtd_pkg::ST_PRIME: begin
        if (!sts.pend_valid || sts.out_free) begin
          state_nxt = sts.at_limit ? prtd_pkg::ST_FINAL : prtd_pkg::ST_NEXT;
        end
      end
      prtd_pkg::ST_NEXT: begin
        state_nxt = sts.cand_eq_high ? prtd_pkg::ST_FINAL : prtd_pkg::ST_CHECK;
      end
      prtd_pkg::ST_FINAL: begin
        if (sts.out_free) state_nxt = prtd_pkg::ST_IDLE;
      end
      default: state_nxt = prtd_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      prtd_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      prtd_pkg::ST_CHECK: begin
        cmd.start_div = !sts.cand_gt_high && !sts.cand_lt2 && !sts.half_lt2;
      end
      prtd_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
      end
      prtd_pkg::ST_TEST: begin
        cmd.next_div = !sts.rem_zero && !sts.next_div_over;
      end
      prtd_pkg::ST_PRIME: begin
        if (!sts.pend_valid || sts.out_free) begin
          cmd.take_prime = 1'b1;
          cmd.set_trunc  = sts.at_limit;
        end
      end
      prtd_pkg::ST_NEXT: begin
        cmd.cand_inc = !sts.cand_eq_high;
      end
      prtd_pkg::ST_FINAL: begin
        cmd.emit_final = sts.out_free;
      end
      default: begin
        cmd      = '0;
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

### hdl/prtd_dpath.sv
module prtd_dpath #(
  parameter int VALUE_WIDTH = 16,
  parameter int MAX_RESULTS = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [prtd_pkg::FIELD_W-1:0]   in_range_low,
  input  logic [prtd_pkg::FIELD_W-1:0]   in_range_high,
  input  prtd_pkg::cmd_t                 cmd,
  output prtd_pkg::sts_t                 sts,
  input  logic                           out_stall,
  output logic                           out_valid,
  output logic [prtd_pkg::FIELD_W-1:0]   out_prime_value,
  output logic [prtd_pkg::COUNT_W-1:0]   out_found_count,
  output logic                           out_last_result,
  output logic                           out_none_found,
  output logic                           out_truncated
);

  localparam int W     = VALUE_WIDTH;
  localparam int FW    = prtd_pkg::FIELD_W;
  localparam int CW    = prtd_pkg::COUNT_W;
  localparam int CNT_W = $clog2(VALUE_WIDTH);

  logic [W-1:0]     cand_r, cand_nxt;
  logic [W-1:0]     high_r, high_nxt;
  logic [W-1:0]     div_r, div_nxt;
  logic [W-1:0]     rem_r, rem_nxt;
  logic [W-1:0]     shreg_r, shreg_nxt;
  logic [W-1:0]     pend_r, pend_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             pend_valid_r, pend_valid_nxt;
  logic             trunc_r, trunc_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [FW-1:0]    out_value_r, out_value_nxt;
  logic [CW-1:0]    out_count_r, out_count_nxt;
  logic             out_last_r, out_last_nxt;
  logic             out_none_r, out_none_nxt;
  logic             out_trunc_r, out_trunc_nxt;

  logic [W-1:0]     half;
  logic [W-1:0]     div_inc;
  logic [W:0]       trial;
  logic [W:0]       diff;
  logic             out_free;
  logic             out_load;

  assign half     = cand_r >> 1;
  assign div_inc  = div_r + W'(1);
  assign trial    = {rem_r, shreg_r[W-1]};
  assign diff     = trial - {1'b0, div_r};
  assign out_free = !out_valid_r || !out_stall;
  assign out_load = (cmd.take_prime && pend_valid_r) || cmd.emit_final;

  always_comb begin
    sts               = '0;
    sts.cand_lt2      = cand_r < W'(2);
    sts.cand_gt_high  = cand_r > high_r;
    sts.cand_eq_high  = cand_r == high_r;
    sts.half_lt2      = half < W'(2);
    sts.div_done      = cnt_r == CNT_W'(VALUE_WIDTH - 1);
    sts.rem_zero      = rem_r == '0;
    sts.next_div_over = div_inc > half;
    sts.pend_valid    = pend_valid_r;
    sts.at_limit      = count_r == CW'(MAX_RESULTS - 1);
    sts.out_free      = out_free;
  end

  // walk and division registers
  always_comb begin
    cand_nxt       = cand_r;
    high_nxt       = high_r;
    div_nxt        = div_r;
    rem_nxt        = rem_r;
    shreg_nxt      = shreg_r;
    cnt_nxt        = cnt_r;
    count_nxt      = count_r;
    pend_nxt       = pend_r;
    pend_valid_nxt = pend_valid_r;
    trunc_nxt      = trunc_r;
    if (cmd.load) begin
      cand_nxt       = W'(in_range_low);
      high_nxt       = W'(in_range_high);
      count_nxt      = '0;
      pend_valid_nxt = 1'b0;
      trunc_nxt      = 1'b0;
    end
    if (cmd.start_div || cmd.next_div) begin
      div_nxt   = cmd.start_div ? W'(2) : div_inc;
      rem_nxt   = '0;
      shreg_nxt = cand_r;
      cnt_nxt   = '0;
    end
    if (cmd.div_step) begin
      rem_nxt   = diff[W] ? trial[W-1:0] : diff[W-1:0];
      shreg_nxt = shreg_r << 1;
      cnt_nxt   = cnt_r + CNT_W'(1);
    end
    if (cmd.take_prime) begin
      pend_nxt       = cand_r;
      pend_valid_nxt = 1'b1;
      count_nxt      = count_r + CW'(1);
    end
    if (cmd.set_trunc) trunc_nxt = cand_r != high_r;
    if (cmd.cand_inc) cand_nxt = cand_r + W'(1);
    if (cmd.emit_final) pend_valid_nxt = 1'b0;
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_value_nxt = out_value_r;
    out_count_nxt = out_count_r;
    out_last_nxt  = out_last_r;
    out_none_nxt  = out_none_r;
    out_trunc_nxt = out_trunc_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_value_nxt = pend_valid_r ? FW'(pend_r) : '0;
      out_count_nxt = pend_valid_r ? count_r : '0;
      out_last_nxt  = cmd.emit_final;
      out_none_nxt  = cmd.emit_final && !pend_valid_r;
      out_trunc_nxt = cmd.emit_final && pend_valid_r && trunc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      trunc_r      <= 1'b0;
      count_r      <= '0;
    end else begin
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      trunc_r      <= trunc_nxt;
      count_r      <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cand_r      <= cand_nxt;
    high_r      <= high_nxt;
    div_r       <= div_nxt;
    rem_r       <= rem_nxt;
    shreg_r     <= shreg_nxt;
    cnt_r       <= cnt_nxt;
    pend_r      <= pend_nxt;
    out_value_r <= out_value_nxt;
    out_count_r <= out_count_nxt;
    out_last_r  <= out_last_nxt;
    out_none_r  <= out_none_nxt;
    out_trunc_r <= out_trunc_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_prime_value = out_value_r;
  assign out_found_count = out_count_r;
  assign out_last_result = out_last_r;
  assign out_none_found  = out_none_r;
  assign out_truncated   = out_trunc_r;

endmodule

### hdl/prime_range_trial_division_unit.sv
// Prime search over an inclusive range by trial division. One request beat
// carries range_low and range_high; the unit walks every candidate in rising
// order, skips zero and one, and tests the rest against divisors 2 .. v/2,
// emitting one result beat per prime with a running count. The final beat of
// a request carries last_result; a range with no prime (or low above high)
// gives a single beat with none_found set and value and count zero. After
// MAX_RESULTS primes the search stops and that final beat carries truncated
// when candidates remained. Each prime is held one step back so that the last
// flag can be set on it, so a prime's beat appears once the next prime is found
// or the range ends. Each trial is a restoring division over the candidate's
// VALUE_WIDTH bits, then a test of the remainder, after which the next
// divisor is tried or the candidate is settled and the walk advances; two and
// three are taken as prime without a division. The shared divider sets the
// rate; one request is worked at a time and the next is taken once the final
// beat is in the output register.
module prime_range_trial_division_unit #(
  parameter int VALUE_WIDTH = 16,
  parameter int MAX_RESULTS = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // request channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [prtd_pkg::FIELD_W-1:0] in_range_low,
  input  logic [prtd_pkg::FIELD_W-1:0] in_range_high,
  // result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [prtd_pkg::FIELD_W-1:0] out_prime_value,
  output logic [prtd_pkg::COUNT_W-1:0] out_found_count,
  output logic                         out_last_result,
  output logic                         out_none_found,
  output logic                         out_truncated
);

  prtd_pkg::cmd_t cmd;
  prtd_pkg::sts_t sts;

  // sequencer: walks candidates and divisors, arbitrates the output register
  prtd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // candidate, divisor, serial divider, pending prime and output register
  prtd_dpath #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .MAX_RESULTS (MAX_RESULTS)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_range_low    (in_range_low),
    .in_range_high   (in_range_high),
    .cmd             (cmd),
    .sts             (sts),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_prime_value (out_prime_value),
    .out_found_count (out_found_count),
    .out_last_result (out_last_result),
    .out_none_found  (out_none_found),
    .out_truncated   (out_truncated)
  );

  // a taken request keeps the unit busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted but unit not busy");

  // a none-found beat is the only beat of its request and carries no prime
  a_none_found_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_none_found |->
      out_last_result && out_prime_value == '0 && out_found_count == '0
      && !out_truncated)
    else $error("malformed none-found beat");

  // truncation only on the final beat at the result limit
  a_trunc_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_truncated |->
      out_last_result && out_found_count == prtd_pkg::COUNT_W'(MAX_RESULTS))
    else $error("truncated beat below the result limit");

  // the running count never passes the limit, and is nonzero on a prime beat
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_none_found |->
      out_found_count != '0
      && out_found_count <= prtd_pkg::COUNT_W'(MAX_RESULTS))
    else $error("found count out of range");

endmodule
